FILE: rtl/core/rrpp_pkg.sv
// Shared types, constants and status mapping for the ranging result postprocess block.
// No dependencies.
`default_nettype none
package rrpp_pkg;
   localparam int RATE_W   = 16;
   localparam int DIV_W    = 32;
   localparam int GAIN_W   = 12;
   localparam int CODE_W   = 8;
   localparam int STAT_W   = 4;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DATA_W = 16;
   localparam int GAIN_SHIFT = 11;

   localparam logic [CSR_IDX_W-1:0] CSR_TARGET = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN   = 4'd1;

   localparam logic [RATE_W-1:0] TARGET_RESET = 16'd2560;
   localparam logic [GAIN_W-1:0] GAIN_RESET   = 12'd2011;
   localparam logic [RATE_W-1:0] SPAD_MID     = 16'h8000;
   localparam logic [RATE_W-1:0] CLIP16       = 16'hFFFF;
   localparam logic [28:0]       ROUND_HALF   = 29'h0400;

   localparam logic [STAT_W-1:0] ST_VALID    = 4'd0;
   localparam logic [STAT_W-1:0] ST_SIGMA    = 4'd1;
   localparam logic [STAT_W-1:0] ST_SIGNAL   = 4'd2;
   localparam logic [STAT_W-1:0] ST_MINCLIP  = 4'd3;
   localparam logic [STAT_W-1:0] ST_BOUNDS   = 4'd4;
   localparam logic [STAT_W-1:0] ST_HW       = 4'd5;
   localparam logic [STAT_W-1:0] ST_NOWRAP   = 4'd6;
   localparam logic [STAT_W-1:0] ST_WRAP     = 4'd7;
   localparam logic [STAT_W-1:0] ST_XTALK    = 4'd8;
   localparam logic [STAT_W-1:0] ST_SYNC     = 4'd9;
   localparam logic [STAT_W-1:0] ST_MINRANGE = 4'd10;
   localparam logic [STAT_W-1:0] ST_NONE     = 4'd11;

   typedef struct packed {
      logic [RATE_W-1:0] dist_mm;
      logic [STAT_W-1:0] status;
      logic              fallback;
   } side_type;

   localparam int SIDE_W = $bits(side_type);

   function automatic logic [STAT_W-1:0] map_status(input logic [CODE_W-1:0] raw,
                                                    input logic [CODE_W-1:0] stream);
      logic [STAT_W-1:0] s;
      case (raw)
         8'd1, 8'd2, 8'd3, 8'd17: s = ST_HW;
         8'd4:  s = ST_SIGNAL;
         8'd5:  s = ST_BOUNDS;
         8'd6:  s = ST_SIGMA;
         8'd7:  s = ST_WRAP;
         8'd8:  s = ST_MINCLIP;
         8'd9:  s = (stream == '0) ? ST_NOWRAP : ST_VALID;
         8'd12: s = ST_XTALK;
         8'd13: s = ST_MINRANGE;
         8'd18: s = ST_SYNC;
         default: s = ST_NONE;
      endcase
      return s;
   endfunction
endpackage
`default_nettype wire

FILE: rtl/core/rrpp_if.sv
// Channel interfaces: measurement items in, result items out, register writes.
// Depends on rrpp_pkg.
`default_nettype none
interface rrpp_req_if import rrpp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CODE_W-1:0] raw_status;
   logic [CODE_W-1:0] meas_stream;
   logic [RATE_W-1:0] effective_spads;
   logic [RATE_W-1:0] ambient_rate;
   logic [RATE_W-1:0] raw_dist_mm;
   logic [RATE_W-1:0] peak_signal_rate;
   modport source (output valid, raw_status, meas_stream, effective_spads, ambient_rate,
                   raw_dist_mm, peak_signal_rate, input ready);
   modport sink (input valid, raw_status, meas_stream, effective_spads, ambient_rate,
                 raw_dist_mm, peak_signal_rate, output ready);
endinterface

interface rrpp_rsp_if import rrpp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [RATE_W-1:0] dist_mm;
   logic [STAT_W-1:0] meas_status;
   logic [RATE_W-1:0] required_spads;
   logic              spad_fallback;
   modport source (output valid, dist_mm, meas_status, required_spads, spad_fallback,
                   input ready);
   modport sink (input valid, dist_mm, meas_status, required_spads, spad_fallback,
                 output ready);
endinterface

interface rrpp_csr_if import rrpp_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/rrpp_front.sv
// Entry stage: gain-corrected range, status map, clipped total rate.
// Depends on rrpp_pkg.
`default_nettype none
module rrpp_front import rrpp_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire logic [CODE_W-1:0] raw_status,
   input  wire logic [CODE_W-1:0] meas_stream,
   input  wire logic [RATE_W-1:0] effective_spads,
   input  wire logic [RATE_W-1:0] ambient_rate,
   input  wire logic [RATE_W-1:0] raw_dist_mm,
   input  wire logic [RATE_W-1:0] peak_signal_rate,
   input  wire logic [GAIN_W-1:0] gain,
   output logic                   out_valid,
   output logic [RATE_W-1:0]      out_range,
   output logic [STAT_W-1:0]      out_status,
   output logic [RATE_W-1:0]      out_total,
   output logic [RATE_W-1:0]      out_spads
);
   logic              valid_ff;
   logic [RATE_W-1:0] range_ff, range_in, total_ff, total_in, spads_ff;
   logic [STAT_W-1:0] status_ff;
   logic [27:0]       prod;
   logic [28:0]       sum;
   logic [RATE_W:0]   rsum;

   always_comb begin
      prod     = raw_dist_mm * gain;
      sum      = {1'b0, prod} + ROUND_HALF;
      range_in = (sum[28:27] != 2'b00) ? CLIP16 : sum[26:11];
      rsum     = {1'b0, peak_signal_rate} + {1'b0, ambient_rate};
      total_in = rsum[RATE_W] ? CLIP16 : rsum[RATE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         range_ff  <= range_in;
         total_ff  <= total_in;
         spads_ff  <= effective_spads;
         status_ff <= map_status(raw_status, meas_stream);
      end
   end

   assign out_valid  = valid_ff;
   assign out_range  = range_ff;
   assign out_status = status_ff;
   assign out_total  = total_ff;
   assign out_spads  = spads_ff;
endmodule
`default_nettype wire

FILE: rtl/core/rrpp_div_cell.sv
// One restoring-division cell: produces one quotient bit per item and registers it.
// No package dependency.
`default_nettype none
module rrpp_div_cell #(
   parameter int NUM_W  = 32,
   parameter int DEN_W  = 16,
   parameter int SIDE_W = 21
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire logic [DEN_W-1:0]  in_rem,
   input  wire logic [NUM_W-1:0]  in_acc,
   input  wire logic [DEN_W-1:0]  in_den,
   input  wire logic [SIDE_W-1:0] in_side,
   output logic                   out_valid,
   output logic [DEN_W-1:0]       out_rem,
   output logic [NUM_W-1:0]       out_acc,
   output logic [DEN_W-1:0]       out_den,
   output logic [SIDE_W-1:0]      out_side
);
   logic              valid_ff;
   logic [DEN_W-1:0]  rem_ff, rem_in, den_ff;
   logic [NUM_W-1:0]  acc_ff, acc_in;
   logic [SIDE_W-1:0] side_ff;
   logic [DEN_W:0]    trial, diff;
   logic              ge;

   always_comb begin
      trial  = {in_rem, in_acc[NUM_W-1]};
      ge     = trial >= {1'b0, in_den};
      diff   = trial - {1'b0, in_den};
      rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      acc_in = {in_acc[NUM_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         acc_ff  <= acc_in;
         den_ff  <= in_den;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_acc   = acc_ff;
   assign out_den   = den_ff;
   assign out_side  = side_ff;
endmodule
`default_nettype wire

FILE: rtl/core/rrpp_div_chain.sv
// Pipelined divider: a row of NUM_W division cells, one quotient bit each.
// Depends on rrpp_div_cell.
`default_nettype none
module rrpp_div_chain #(
   parameter int NUM_W  = 32,
   parameter int DEN_W  = 16,
   parameter int SIDE_W = 21
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire logic [NUM_W-1:0]  in_num,
   input  wire logic [DEN_W-1:0]  in_den,
   input  wire logic [SIDE_W-1:0] in_side,
   output logic                   out_valid,
   output logic [NUM_W-1:0]       out_quot,
   output logic [SIDE_W-1:0]      out_side
);
   logic              v    [0:NUM_W];
   logic [DEN_W-1:0]  rem  [0:NUM_W];
   logic [NUM_W-1:0]  acc  [0:NUM_W];
   logic [DEN_W-1:0]  den  [0:NUM_W];
   logic [SIDE_W-1:0] side [0:NUM_W];

   assign v[0]    = in_valid;
   assign rem[0]  = '0;
   assign acc[0]  = in_num;
   assign den[0]  = in_den;
   assign side[0] = in_side;

   for (genvar i = 0; i < NUM_W; i++) begin : g_cell
      rrpp_div_cell #(.NUM_W(NUM_W), .DEN_W(DEN_W), .SIDE_W(SIDE_W)) u_cell (
         .clock(clock), .reset(reset), .en(en),
         .in_valid(v[i]), .in_rem(rem[i]), .in_acc(acc[i]), .in_den(den[i]),
         .in_side(side[i]),
         .out_valid(v[i+1]), .out_rem(rem[i+1]), .out_acc(acc[i+1]), .out_den(den[i+1]),
         .out_side(side[i+1])
      );
   end

   assign out_valid = v[NUM_W];
   assign out_quot  = acc[NUM_W];
   assign out_side  = side[NUM_W];
endmodule
`default_nettype wire

FILE: rtl/core/ranging_result_postprocess_core.sv
// Ranging result postprocess: gain-corrected range, status map, SPAD target.
// Pipeline: entry stage, two 32-cell divider rows, output register.
// Throughput one item per cycle; the whole pipeline holds while a result waits.
// Reset (synchronous) empties the pipeline and loads the register defaults.
// Depends on rrpp_pkg, rrpp_if, rrpp_front, rrpp_div_chain.
`default_nettype none
module ranging_result_postprocess_core import rrpp_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   rrpp_req_if.sink   req_bus,
   rrpp_rsp_if.source rsp_bus,
   rrpp_csr_if.sink   csr_bus
);
   logic              adv;
   logic [RATE_W-1:0] target_ff;
   logic [GAIN_W-1:0] gain_ff;

   logic              f_valid;
   logic [RATE_W-1:0] f_range, f_total, f_spads;
   logic [STAT_W-1:0] f_status;

   side_type          side1, side1_out, side2, side2_out;
   logic              c1_valid, c2_valid;
   logic [DIV_W-1:0]  q1, q2;

   logic              rsp_valid_ff;
   logic [RATE_W-1:0] range_ff, req_ff, req_in;
   logic [STAT_W-1:0] status_ff;
   logic              fb_ff;

   assign adv           = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = adv;
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= TARGET_RESET;
         gain_ff   <= GAIN_RESET;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_TARGET: target_ff <= csr_bus.data;
            CSR_GAIN:   gain_ff   <= csr_bus.data[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   rrpp_front u_front (
      .clock(clock), .reset(reset), .en(adv), .in_valid(req_bus.valid),
      .raw_status(req_bus.raw_status), .meas_stream(req_bus.meas_stream),
      .effective_spads(req_bus.effective_spads), .ambient_rate(req_bus.ambient_rate),
      .raw_dist_mm(req_bus.raw_dist_mm), .peak_signal_rate(req_bus.peak_signal_rate),
      .gain(gain_ff),
      .out_valid(f_valid), .out_range(f_range), .out_status(f_status),
      .out_total(f_total), .out_spads(f_spads)
   );

   always_comb begin
      side1.dist_mm  = f_range;
      side1.status   = f_status;
      side1.fallback = (f_spads == '0);
   end

   rrpp_div_chain #(.NUM_W(DIV_W), .DEN_W(RATE_W), .SIDE_W(SIDE_W)) u_div_rate (
      .clock(clock), .reset(reset), .en(adv), .in_valid(f_valid),
      .in_num({f_total, {RATE_W{1'b0}}}), .in_den(f_spads), .in_side(side1),
      .out_valid(c1_valid), .out_quot(q1), .out_side(side1_out)
   );

   always_comb begin
      side2          = side1_out;
      side2.fallback = side1_out.fallback || (q1 == '0);
   end

   rrpp_div_chain #(.NUM_W(DIV_W), .DEN_W(DIV_W), .SIDE_W(SIDE_W)) u_div_spads (
      .clock(clock), .reset(reset), .en(adv), .in_valid(c1_valid),
      .in_num({target_ff, {RATE_W{1'b0}}}), .in_den(q1), .in_side(side2),
      .out_valid(c2_valid), .out_quot(q2), .out_side(side2_out)
   );

   always_comb begin
      if (side2_out.fallback) begin
         req_in = SPAD_MID;
      end else if (q2[DIV_W-1:RATE_W] != '0) begin
         req_in = CLIP16;
      end else begin
         req_in = q2[RATE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= c2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         range_ff  <= side2_out.dist_mm;
         status_ff <= side2_out.status;
         req_ff    <= req_in;
         fb_ff     <= side2_out.fallback;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.dist_mm        = range_ff;
   assign rsp_bus.meas_status    = status_ff;
   assign rsp_bus.required_spads = req_ff;
   assign rsp_bus.spad_fallback  = fb_ff;
endmodule
`default_nettype wire

FILE: verif/rrpp_tb_if.sv
// Testbench-side note: channel interfaces come from rtl/core/rrpp_if.sv.
// This file only holds a small helper package of result types for the bench.
// Depends on rrpp_pkg.
package rrpp_tb_pkg;
   import rrpp_pkg::*;
   typedef struct packed {
      logic [RATE_W-1:0] dist_mm;
      logic [STAT_W-1:0] status;
      logic [RATE_W-1:0] spads;
      logic              fallback;
   } range_result_type;
endpackage

FILE: verif/ranging_result_postprocess_core_tb.sv
// Testbench for ranging_result_postprocess_core: directed and random measurement
// items, predicted results compared in order. Depends on rrpp_pkg, rrpp_if, rrpp_tb_pkg.
module ranging_result_postprocess_core_tb;
   import rrpp_pkg::*;
   import rrpp_tb_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 0;
   logic reset = 1;
   rrpp_req_if req_bus();
   rrpp_rsp_if rsp_bus();
   rrpp_csr_if csr_bus();

   ranging_result_postprocess_core dut (.clock(clock), .reset(reset), .req_bus(req_bus),
                                        .rsp_bus(rsp_bus), .csr_bus(csr_bus));

   logic [RATE_W-1:0] tgt_rate;
   logic [GAIN_W-1:0] gain;
   range_result_type  expected_q[$];
   int                errors = 0;
   int                items_sent = 0;
   int                results_seen = 0;
   int                fallbacks_seen = 0;

   initial forever #1 clock = ~clock;

   initial begin
      #2000000;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic logic [STAT_W-1:0] status_of(logic [7:0] raw, logic [7:0] stream);
      case (raw)
         8'd1, 8'd2, 8'd3, 8'd17: return ST_HW;
         8'd4: return ST_SIGNAL;
         8'd5: return ST_BOUNDS;
         8'd6: return ST_SIGMA;
         8'd7: return ST_WRAP;
         8'd8: return ST_MINCLIP;
         8'd9: return stream == 0 ? ST_NOWRAP : ST_VALID;
         8'd12: return ST_XTALK;
         8'd13: return ST_MINRANGE;
         8'd18: return ST_SYNC;
         default: return ST_NONE;
      endcase
   endfunction

   function automatic range_result_type postprocess(logic [7:0] raw, logic [7:0] stream,
         logic [15:0] spads, logic [15:0] ambient, logic [15:0] range_in,
         logic [15:0] peak);
      range_result_type r;
      logic [31:0] scaled;
      logic [16:0] total;
      logic [47:0] per_spad;
      logic [47:0] quotient;
      scaled = (32'(range_in) * 32'(gain) + 32'h400) >> GAIN_SHIFT;
      r.dist_mm = scaled > 32'hFFFF ? 16'hFFFF : scaled[15:0];
      r.status = status_of(raw, stream);
      r.spads = SPAD_MID;
      r.fallback = 1'b1;
      if (spads != 0) begin
         total = 17'(peak) + 17'(ambient);
         if (total > 17'hFFFF) total = 17'hFFFF;
         per_spad = (48'(total) << 16) / 48'(spads);
         if (per_spad != 0) begin
            quotient = (48'(tgt_rate) << 16) / per_spad;
            r.spads = quotient > 48'hFFFF ? 16'hFFFF : quotient[15:0];
            r.fallback = 1'b0;
         end
      end
      return r;
   endfunction

   function automatic int gap_length();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // result checker and receiver stalls
   initial begin
      int stall;
      rsp_bus.ready = 0;
      stall = 0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            stall--;
            rsp_bus.ready <= 0;
         end else begin
            rsp_bus.ready <= 1;
            stall = ($urandom_range(0, 3) == 0) ? gap_length() : 0;
         end
      end
   end

   always @(posedge clock) begin
      range_result_type e;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         results_seen++;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result range %0d status %0d", $time,
                     rsp_bus.dist_mm, rsp_bus.meas_status);
         end else begin
            e = expected_q.pop_front();
            if (e.fallback) fallbacks_seen++;
            if (rsp_bus.dist_mm !== e.dist_mm) begin
               errors++;
               $display("%0t: dist_mm expected %h actual %h", $time, e.dist_mm,
                        rsp_bus.dist_mm);
            end
            if (rsp_bus.meas_status !== e.status) begin
               errors++;
               $display("%0t: meas_status expected %0d actual %0d", $time, e.status,
                        rsp_bus.meas_status);
            end
            if (rsp_bus.required_spads !== e.spads) begin
               errors++;
               $display("%0t: required_spads expected %h actual %h", $time, e.spads,
                        rsp_bus.required_spads);
            end
            if (rsp_bus.spad_fallback !== e.fallback) begin
               errors++;
               $display("%0t: spad_fallback expected %b actual %b", $time, e.fallback,
                        rsp_bus.spad_fallback);
            end
         end
      end
   end

   task automatic send_item(logic [7:0] raw, logic [7:0] stream, logic [15:0] spads,
         logic [15:0] ambient, logic [15:0] range_in, logic [15:0] peak);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         req_bus.valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid <= 1;
      req_bus.raw_status <= raw;
      req_bus.meas_stream <= stream;
      req_bus.effective_spads <= spads;
      req_bus.ambient_rate <= ambient;
      req_bus.raw_dist_mm <= range_in;
      req_bus.peak_signal_rate <= peak;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      expected_q.push_back(postprocess(raw, stream, spads, ambient, range_in, peak));
      items_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_bus.valid <= 0;
      while (expected_q.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [15:0] value);
      csr_bus.valid <= 1;
      csr_bus.index <= idx;
      csr_bus.data <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      if (idx == CSR_TARGET) tgt_rate = value;
      else if (idx == CSR_GAIN) gain = value[GAIN_W-1:0];
      @(negedge clock);
      csr_bus.valid <= 0;
      @(negedge clock);
   endtask

   task automatic send_random(int count);
      logic [15:0] spads;
      logic [7:0] raw;
      repeat (count) begin
         raw = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 19));
         case ($urandom_range(0, 7))
            0: spads = 0;
            1: spads = 16'($urandom_range(1, 4));
            2: spads = 16'hFFFF;
            default: spads = 16'($urandom);
         endcase
         send_item(raw, ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom), spads,
                   ($urandom_range(0, 5) == 0) ? 16'd0 : 16'($urandom),
                   16'($urandom), ($urandom_range(0, 5) == 0) ? 16'd0 : 16'($urandom));
      end
   endtask

   task automatic test_status_map();
      for (int r = 0; r <= 19; r++) send_item(8'(r), 8'd1, 16'h0100, 16'd50, 16'd1000, 16'd200);
      send_item(8'd9, 8'd0, 16'h0100, 16'd50, 16'd1000, 16'd200);
      send_item(8'd255, 8'd255, 16'h0100, 16'd50, 16'd1000, 16'd200);
   endtask

   task automatic test_spad_extremes();
      send_item(8'd9, 8'd3, 16'd0, 16'd100, 16'hFFFF, 16'd100);
      send_item(8'd9, 8'd3, 16'hFFFF, 16'd0, 16'd0, 16'd0);
      send_item(8'd9, 8'd3, 16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_item(8'd9, 8'd3, 16'hFFFF, 16'd0, 16'd1, 16'd1);
   endtask

   task automatic test_register_settings();
      logic [15:0] targets[4] = '{16'd0, 16'hFFFF, 16'd1, 16'd2560};
      logic [15:0] gains[4]   = '{16'hFFFF, 16'd0, 16'd2048, 16'd2011};
      for (int i = 0; i < 4; i++) begin
         drain();
         write_register(CSR_TARGET, targets[i]);
         write_register(CSR_GAIN, gains[i]);
         write_register(4'd2 + 4'(i), 16'($urandom));
         test_spad_extremes();
         send_random(60);
      end
   endtask

   task automatic test_random_traffic();
      repeat (5) begin
         drain();
         write_register(CSR_TARGET, 16'($urandom));
         write_register(CSR_GAIN, 16'($urandom));
         send_random(250);
      end
   endtask

   initial begin
      req_bus.valid = 0;
      req_bus.raw_status = 0;
      req_bus.meas_stream = 0;
      req_bus.effective_spads = 0;
      req_bus.ambient_rate = 0;
      req_bus.raw_dist_mm = 0;
      req_bus.peak_signal_rate = 0;
      csr_bus.valid = 0;
      csr_bus.index = 0;
      csr_bus.data = 0;
      tgt_rate = TARGET_RESET;
      gain = GAIN_RESET;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(negedge clock);
      test_status_map();
      test_spad_extremes();
      test_register_settings();
      test_random_traffic();
      drain();
      $display("Sent %0d measurement items, checked %0d results (%0d SPAD fallbacks).",
               items_sent, results_seen, fallbacks_seen);
      $display("Covered all status codes, register extremes and zero-divisor cases.");
      if (errors == 0 && expected_q.size() == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end
endmodule
